// ===== hw/rtl/ilir_pkg.sv =====
package ilir_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int DATA_W_DEF = 32;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_ENTRY   = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_INSERT = 2'd3
    } status_t;

    // per-cell action
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_ZERO   = 3'd1,
        CELL_INSERT = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_READ   = 3'd4
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_DRAIN = 2'd2
    } state_t;

    typedef struct packed {
        cell_op_t op;
        logic     load;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/indexed_list_insert_remove_top.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------
// in       | in_valid / in_ready  | mode, index, value_in
// out      | out_valid / out_ready| value_out, status, count_out
//
// an item moves through accept in idle, the exec step in which every cell of
// the chain shifts or taps at once, and the drain step that folds the taps
// into the output register
// a waiting result does not block the next accept; a stalled output holds the
// following item in the drain step until the register frees up
// reset clears the count and the control state only; entries need no clearing
module indexed_list_insert_remove_top
    import ilir_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [MODE_W-1:0]         mode,
    input  logic signed [INDEX_W-1:0] index,
    input  logic [VALUE_W-1:0]        value_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [VALUE_W-1:0]        value_out,
    output logic [STATUS_W-1:0]       status,
    output logic [CW-1:0]             count_out
);

    localparam int AW = $clog2(DEPTH);

    cell_ctl_t             ctl;
    logic [AW-1:0]         cell_pos;
    logic [DATA_WIDTH-1:0] cell_word;
    logic [DATA_WIDTH-1:0] vals [DEPTH];
    logic [DATA_WIDTH-1:0] taps [DEPTH];
    logic [DATA_WIDTH-1:0] tap_or;
    logic [VALUE_W-1:0]    tap_word;
    logic [VALUE_W-1:0]    value_out_reg;

    // sequencing, count and status
    ilir_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .index     (index),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .count_out (count_out),
        .ctl       (ctl),
        .cell_pos  (cell_pos),
        .cell_word (cell_word)
    );

    // the chain: cells above pos take from the left neighbor on insert, cells
    // at or above pos from the right on remove; the ends feed back their own word
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            ilir_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .AW         (AW)
            ) u_cell (
                .clk       (clk),
                .op        (ctl.op),
                .pos       (cell_pos),
                .slot      (AW'(gi)),
                .word      (cell_word),
                .left_val  (vals[(gi == 0) ? 0 : gi - 1]),
                .right_val (vals[(gi == DEPTH - 1) ? gi : gi + 1]),
                .val       (vals[gi]),
                .tap       (taps[gi])
            );
        end
    endgenerate

    // at most one cell taps a nonzero word, so an or across the row selects it
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tap_or = tap_or | taps[i];
        end
    end

    // results are reported in a 32-bit word
    generate
        if (DATA_WIDTH >= VALUE_W)
        begin : g_out_wide
            assign tap_word = tap_or[VALUE_W-1:0];
        end
        else
        begin : g_out_narrow
            assign tap_word = {{(VALUE_W - DATA_WIDTH){1'b0}}, tap_or};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            value_out_reg <= tap_word;
        end
    end

    assign value_out = value_out_reg;

endmodule

// ===== hw/rtl/ilir_cell.sv =====
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int AW         = 6
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [AW-1:0]         pos,
    input  logic [AW-1:0]         slot,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_val,
    input  logic [DATA_WIDTH-1:0] right_val,
    output logic [DATA_WIDTH-1:0] val,
    output logic [DATA_WIDTH-1:0] tap
);

    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] val_next;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic [DATA_WIDTH-1:0] tap_next;
    logic                  hit;

    assign hit = (slot == pos);

    always_comb
    begin
        val_next = val_reg;
        tap_next = tap_reg;
        case (op)
            CELL_ZERO:
            begin
                tap_next = '0;
            end
            CELL_INSERT:
            begin
                tap_next = '0;
                if (slot > pos)
                begin
                    val_next = left_val;
                end
                else if (hit)
                begin
                    val_next = word;
                end
            end
            CELL_REMOVE:
            begin
                tap_next = hit ? val_reg : '0;
                if (slot >= pos)
                begin
                    val_next = right_val;
                end
            end
            CELL_READ:
            begin
                tap_next = hit ? val_reg : '0;
            end
            default:
            begin
                tap_next = tap_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        tap_reg <= tap_next;
    end

    assign val = val_reg;
    assign tap = tap_reg;

endmodule

// ===== hw/rtl/ilir_ctrl.sv =====
module ilir_ctrl
    import ilir_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic signed [INDEX_W-1:0] index,
    input  logic [VALUE_W-1:0]    value_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [CW-1:0]         count_out,
    output cell_ctl_t             ctl,
    output logic [AW-1:0]         cell_pos,
    output logic [DATA_WIDTH-1:0] cell_word
);

    localparam int SW = ((CW > INDEX_W) ? CW : INDEX_W) + 2;

    state_t                  state_reg, state_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [INDEX_W-1:0]      idx_reg, idx_next;
    logic [DATA_WIDTH-1:0]   word_reg, word_next;
    logic [CW-1:0]           count_reg, count_next;
    status_t                 pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [CW-1:0]           out_count_reg, out_count_next;

    logic [DATA_WIDTH-1:0]   word_in;
    logic signed [SW-1:0]    idx_ext;
    logic signed [SW-1:0]    cnt_ext;
    logic signed [SW-1:0]    rr_pos;
    logic                    rr_ok;
    logic                    ins_bad;
    logic                    full;

    // words are kept to their low DATA_WIDTH bits
    generate
        if (DATA_WIDTH >= VALUE_W)
        begin : g_wide
            assign word_in = DATA_WIDTH'(value_in);
        end
        else
        begin : g_narrow
            assign word_in = value_in[DATA_WIDTH-1:0];
        end
    endgenerate

    assign idx_ext = {{(SW - INDEX_W){idx_reg[INDEX_W-1]}}, idx_reg};
    assign cnt_ext = {{(SW - CW){1'b0}}, count_reg};
    assign rr_pos  = idx_reg[INDEX_W-1] ? (idx_ext + cnt_ext) : idx_ext;
    assign rr_ok   = !rr_pos[SW-1] && (rr_pos < cnt_ext);
    assign ins_bad = idx_reg[INDEX_W-1] || (idx_ext > cnt_ext);
    assign full    = (count_reg == CW'(DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        in_ready        = 1'b0;
        ctl.op          = CELL_HOLD;
        ctl.load        = 1'b0;
        cell_pos        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode;
                    idx_next   = index;
                    word_next  = word_in;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                pend_next = ST_OK;
                ctl.op    = CELL_ZERO;
                unique case (mode_reg)
                    MODE_APPEND:
                    begin
                        if (full)
                        begin
                            pend_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.op     = CELL_INSERT;
                            cell_pos   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (ins_bad)
                        begin
                            pend_next = ST_BAD_INSERT;
                        end
                        else if (full)
                        begin
                            pend_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.op     = CELL_INSERT;
                            cell_pos   = idx_ext[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (!rr_ok)
                        begin
                            pend_next = ST_NO_ENTRY;
                        end
                        else
                        begin
                            ctl.op     = CELL_REMOVE;
                            cell_pos   = rr_pos[AW-1:0];
                            count_next = count_reg - CW'(1);
                        end
                    end
                    MODE_READ:
                    begin
                        if (!rr_ok)
                        begin
                            pend_next = ST_NO_ENTRY;
                        end
                        else
                        begin
                            ctl.op   = CELL_READ;
                            cell_pos = rr_pos[AW-1:0];
                        end
                    end
                    MODE_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        pend_next = ST_OK;
                    end
                endcase
                state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        pend_reg       <= pend_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign cell_word = word_reg;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign count_out = out_count_reg;

endmodule

// ===== hw/rtl/ilir_check.sv =====
module ilir_check
    import ilir_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [VALUE_W-1:0]    value_out,
    input logic [STATUS_W-1:0]   status,
    input logic [CW-1:0]         count_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_out)
            && $stable(status) && $stable(count_out))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while another is at work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_out <= CW'(DEPTH))
        else $error("count beyond capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count_out == CW'(DEPTH))
        else $error("full reported below capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value_out == '0)
        else $error("failed item returned a word");

endmodule

bind indexed_list_insert_remove_top ilir_check #(
    .DEPTH (DEPTH),
    .CW    (CW)
) u_ilir_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .status    (status),
    .count_out (count_out)
);
